// File: rtl/hbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_pkg: shared types and constants for the HSV bulb color driver
// Item formats, command codes, multiplier lane control and hue helpers.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int unsigned HUE_SECTOR = 43;
  localparam int unsigned FULL_SCALE = 255;
  localparam int unsigned REM_SCALE  = 6;

  typedef enum logic [1:0] {
    CMD_POWER      = 2'd0,
    CMD_LEVEL      = 2'd1,
    CMD_HUE        = 2'd2,
    CMD_SATURATION = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_duty;
    logic [7:0] green_duty;
    logic [7:0] blue_duty;
  } out_item_t;

  // Control of one serial multiplier lane
  typedef struct packed {
    logic load;
    logic step;
  } mul_ctrl_t;

  // Hue region 0..5, each HUE_SECTOR wide but the last, which runs up to 255
  function automatic logic [2:0] hue_region(input logic [7:0] h);
    logic [2:0] r;
    if (h >= 8'(5 * HUE_SECTOR)) begin
      r = 3'd5;
    end else if (h >= 8'(4 * HUE_SECTOR)) begin
      r = 3'd4;
    end else if (h >= 8'(3 * HUE_SECTOR)) begin
      r = 3'd3;
    end else if (h >= 8'(2 * HUE_SECTOR)) begin
      r = 3'd2;
    end else if (h >= 8'(HUE_SECTOR)) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  // Offset within the region, scaled by REM_SCALE (0..252)
  function automatic logic [7:0] hue_rem(input logic [7:0] h);
    logic [7:0] base;
    logic [7:0] off;
    base = 8'(32'(hue_region(h)) * HUE_SECTOR);
    off  = h - base;
    return 8'(32'(off) * REM_SCALE);
  endfunction

endpackage

// File: rtl/hsv_bulb_color_driver.sv
`timescale 1ns / 1ps
// Flow: an accepted item runs prepare, four digit steps of the 2-bit serial
//   multipliers, a reload, four more digit steps, then output select, which
//   waits in S_DONE until the output register is free. An item is taken only
//   in S_IDLE, so no new item is taken while the last one is still in work.
//   The next item is taken while a finished result still waits for out_ready.
// Reset: rst_n (synchronous) clears power, level, hue, saturation and control.
// ----------------------------------------------------------------------------
// hsv_bulb_color_driver: RGB lamp duty generator from HSV attributes
// Each item writes one attribute; the block answers with new R, G, B duties.
// ----------------------------------------------------------------------------
module hsv_bulb_color_driver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hbd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hbd_pkg::out_item_t out_data
);
  import hbd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_MUL1  = 6'b000100,
    S_LOAD2 = 6'b001000,
    S_MUL2  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t    state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Lamp attributes
  logic       power_r, power_nxt;
  logic [7:0] level_r, level_nxt;
  logic [7:0] hue_r, hue_nxt;
  logic [7:0] sat_r, sat_nxt;

  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  logic       in_acc;
  logic       out_load;
  logic [7:0] v;
  logic [7:0] rem;
  logic [2:0] region;

  // Lane 0: s*rem, then q = v*(255 - that>>8)
  // Lane 1: s*(255-rem), then t = v*(255 - that>>8)
  // Lane 2: p = v*(255-s), loaded once
  mul_ctrl_t  ctrl0, ctrl1, ctrl2;
  logic [7:0] mc0, mc1, mc2;
  logic [7:0] mp0, mp1, mp2;
  logic [7:0] hi0, hi1, hi2;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign v      = power_r ? level_r : 8'h00;
  assign rem    = hue_rem(hue_r);
  assign region = hue_region(hue_r);

  // Take the item: write the addressed attribute
  always_comb begin
    power_nxt = power_r;
    level_nxt = level_r;
    hue_nxt   = hue_r;
    sat_nxt   = sat_r;
    if (in_acc) begin
      unique case (cmd_t'(in_data.command))
        CMD_POWER:      power_nxt = in_data.value[0];
        CMD_LEVEL:      level_nxt = in_data.value;
        CMD_HUE:        hue_nxt   = in_data.value;
        CMD_SATURATION: sat_nxt   = in_data.value;
        default:        sat_nxt   = in_data.value;
      endcase
    end
  end

  // Lane operands: first round in S_PREP, second round in S_LOAD2
  always_comb begin
    ctrl0.load = (state_r == S_PREP) || (state_r == S_LOAD2);
    ctrl0.step = (state_r == S_MUL1) || (state_r == S_MUL2);
    ctrl1      = ctrl0;
    ctrl2.load = (state_r == S_PREP);
    ctrl2.step = (state_r == S_MUL1);

    mc2 = v;
    mp2 = 8'(FULL_SCALE) - sat_r;
    if (state_r == S_PREP) begin
      mc0 = sat_r;
      mp0 = rem;
      mc1 = sat_r;
      mp1 = 8'(FULL_SCALE) - rem;
    end else begin
      mc0 = v;
      mp0 = 8'(FULL_SCALE) - hi0;
      mc1 = v;
      mp1 = 8'(FULL_SCALE) - hi1;
    end
  end

  hbd_serial_mul u_lane0 (.clk(clk), .ctrl(ctrl0), .mcand(mc0), .mplier(mp0),
                          .product_hi(hi0));
  hbd_serial_mul u_lane1 (.clk(clk), .ctrl(ctrl1), .mcand(mc1), .mplier(mp1),
                          .product_hi(hi1));
  hbd_serial_mul u_lane2 (.clk(clk), .ctrl(ctrl2), .mcand(mc2), .mplier(mp2),
                          .product_hi(hi2));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = S_MUL1;
        cnt_nxt   = 2'd0;
      end
      S_MUL1: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = S_LOAD2;
        end
      end
      S_LOAD2: begin
        state_nxt = S_MUL2;
        cnt_nxt   = 2'd0;
      end
      S_MUL2: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Region mux: p = hi2, q = hi0, t = hi1
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    out_nxt = out_r;
    if (out_load) begin
      if (sat_r == 8'h00) begin
        out_nxt = '{red_duty: v, green_duty: v, blue_duty: v};
      end else begin
        unique case (region)
          3'd0:    out_nxt = '{red_duty: v,   green_duty: hi1, blue_duty: hi2};
          3'd1:    out_nxt = '{red_duty: hi0, green_duty: v,   blue_duty: hi2};
          3'd2:    out_nxt = '{red_duty: hi2, green_duty: v,   blue_duty: hi1};
          3'd3:    out_nxt = '{red_duty: hi2, green_duty: hi0, blue_duty: v};
          3'd4:    out_nxt = '{red_duty: hi1, green_duty: hi2, blue_duty: v};
          default: out_nxt = '{red_duty: v,   green_duty: hi2, blue_duty: hi0};
        endcase
      end
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      power_r     <= 1'b0;
      level_r     <= 8'h00;
      hue_r       <= 8'h00;
      sat_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      power_r     <= power_nxt;
      level_r     <= level_nxt;
      hue_r       <= hue_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_PREP)
    else $error("accepted item did not start preparation");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid && !out_ready |=> state_r == S_DONE)
    else $error("result dropped while output stalled");

  a_mul1_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL1 && cnt_r == 2'd3 |=> state_r == S_LOAD2)
    else $error("first multiply round ran wrong length");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready)
    else $error("input ready while an item is in flight");
`endif

endmodule

// File: rtl/hbd_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_serial_mul: 8x8 multiplier lane, one 2-bit digit per cycle while step is set
// Load sets the operands; four steps leave the 16-bit product in place.
// ----------------------------------------------------------------------------
module hbd_serial_mul (
  input  logic              clk,
  input  hbd_pkg::mul_ctrl_t ctrl,
  input  logic [7:0]        mcand,
  input  logic [7:0]        mplier,
  output logic [7:0]        product_hi
);
  import hbd_pkg::*;

  logic [7:0]  mcand_r;
  logic [15:0] acc_r;     // high byte: partial sum, low byte: multiplier digits
  logic [15:0] acc_nxt;
  logic [9:0]  sum;

  // Add the multiplicand times the lowest digit, then shift right one digit
  assign sum = 10'(acc_r[15:8]) + 10'(mcand_r) * 10'(acc_r[1:0]);

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.load) begin
      acc_nxt = {8'h00, mplier};
    end else if (ctrl.step) begin
      acc_nxt = {sum, acc_r[7:2]};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ctrl.load) begin
      mcand_r <= mcand;
    end
  end

  assign product_hi = acc_r[15:8];

endmodule
